### design/wwsm_pkg.sv
// Shared constants, types and character helpers for the whole-word substring matcher.
// No dependencies; imported by every module of the block.
package wwsm_pkg;

    localparam int NEEDLE_MAX_DEF     = 32;
    localparam int MAX_LINE_CHARS_DEF = 1000;
    localparam int NEEDLE_STORE       = 32;
    localparam int CHAR_W             = 8;
    localparam int CFG_IDX_W          = 3;
    localparam int CFG_DATA_W         = 64;
    localparam int NEEDLE_LEN_W       = 6;

    localparam logic [CHAR_W-1:0] CH_UPPER_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z   = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LOWER_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z   = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_DIGIT_0   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_DIGIT_9   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UNDERLINE = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_AT        = 8'h40;
    localparam logic [CHAR_W-1:0] CH_DOLLAR    = 8'h24;
    localparam logic [CHAR_W-1:0] CH_HASH      = 8'h23;
    localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NEEDLE_LO     = 3'd0,
        REG_NEEDLE_MID_LO = 3'd1,
        REG_NEEDLE_MID_HI = 3'd2,
        REG_NEEDLE_HI     = 3'd3,
        REG_NEEDLE_LEN    = 3'd4,
        REG_MATCH_CASE    = 3'd5,
        REG_WHOLE_WORD    = 3'd6
    } wwsm_reg_t;

    typedef struct packed {
        logic                    len_ok;
        logic                    match_case;
        logic                    whole_word;
        logic [NEEDLE_LEN_W-1:0] len;
    } wwsm_mode_t;

    function automatic logic is_sep(input logic [CHAR_W-1:0] c);
        logic word;
        word = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
               (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
               (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) ||
               c == CH_UNDERLINE || c == CH_AT || c == CH_DOLLAR || c == CH_HASH;
        return !word;
    endfunction

    function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c,
                                                    input logic match_case);
        if (!match_case && c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

endpackage

### design/wwsm_cfg.sv
// Configuration registers and the registered, window-aligned copy of the needle.
// Depends on wwsm_pkg.
module wwsm_cfg #(
    parameter int NEEDLE_MAX = wwsm_pkg::NEEDLE_MAX_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    input  logic [wwsm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wwsm_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic [NEEDLE_MAX-1:0][wwsm_pkg::CHAR_W-1:0] align,
    output logic [NEEDLE_MAX-1:0]              care,
    output logic [NEEDLE_MAX:0]                prev_sel,
    output wwsm_pkg::wwsm_mode_t               mode
);
    import wwsm_pkg::*;

    localparam int NLIM = (NEEDLE_MAX < NEEDLE_STORE) ? NEEDLE_MAX : NEEDLE_STORE;
    localparam int POS_W = 7;

    logic [3:0][CFG_DATA_W-1:0]         needle_reg;
    logic [NEEDLE_LEN_W-1:0]            len_reg;
    logic                               match_case_reg;
    logic                               whole_word_reg;

    logic [NEEDLE_MAX-1:0][CHAR_W-1:0]  align_reg, align_next;
    logic [NEEDLE_MAX-1:0]              care_reg, care_next;
    logic [NEEDLE_MAX:0]                prev_sel_reg, prev_sel_next;
    wwsm_mode_t                         mode_reg, mode_next;

    logic [NEEDLE_STORE*CHAR_W-1:0]     needle_vec;
    logic                               len_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            needle_reg     <= '0;
            len_reg        <= '0;
            match_case_reg <= 1'b0;
            whole_word_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_NEEDLE_LO:     needle_reg[0]  <= cfg_data;
                REG_NEEDLE_MID_LO: needle_reg[1]  <= cfg_data;
                REG_NEEDLE_MID_HI: needle_reg[2]  <= cfg_data;
                REG_NEEDLE_HI:     needle_reg[3]  <= cfg_data;
                REG_NEEDLE_LEN:    len_reg        <= cfg_data[NEEDLE_LEN_W-1:0];
                REG_MATCH_CASE:    match_case_reg <= cfg_data[0];
                REG_WHOLE_WORD:    whole_word_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign needle_vec = needle_reg;
    assign len_ok = (len_reg != '0) && ({1'b0, len_reg} <= POS_W'(NLIM));

    // window position k holds needle char len-1-k
    for (genvar k = 0; k < NEEDLE_MAX; k++) begin : g_align
        logic [NEEDLE_LEN_W-1:0] m_idx;
        assign m_idx = len_reg - NEEDLE_LEN_W'(k) - NEEDLE_LEN_W'(1);
        assign align_next[k] = needle_vec[{m_idx[4:0], 3'b000} +: CHAR_W];
        assign care_next[k]  = len_ok && (POS_W'(k) < {1'b0, len_reg});
    end

    for (genvar k = 0; k <= NEEDLE_MAX; k++) begin : g_prev
        assign prev_sel_next[k] = ({1'b0, len_reg} == POS_W'(k));
    end

    always_comb begin
        mode_next.len_ok     = len_ok;
        mode_next.match_case = match_case_reg;
        mode_next.whole_word = whole_word_reg;
        mode_next.len        = len_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            care_reg     <= '0;
            prev_sel_reg <= '0;
            mode_reg     <= '0;
        end else begin
            care_reg     <= care_next;
            prev_sel_reg <= prev_sel_next;
            mode_reg     <= mode_next;
        end
    end

    always_ff @(posedge aclk) begin
        align_reg <= align_next;
    end

    assign align    = align_reg;
    assign care     = care_reg;
    assign prev_sel = prev_sel_reg;
    assign mode     = mode_reg;

endmodule

### design/wwsm_match.sv
// Parallel judge of a needle occurrence ending at the newest char of a window.
// Depends on wwsm_pkg; fed by wwsm_cfg outputs.
module wwsm_match #(
    parameter int NEEDLE_MAX = wwsm_pkg::NEEDLE_MAX_DEF,
    parameter int CNT_W      = 11
) (
    input  logic [NEEDLE_MAX:0][wwsm_pkg::CHAR_W-1:0]   window,
    input  logic [CNT_W-1:0]                            count,
    input  logic                                        follower_sep,
    input  logic [NEEDLE_MAX-1:0][wwsm_pkg::CHAR_W-1:0] align,
    input  logic [NEEDLE_MAX-1:0]                       care,
    input  logic [NEEDLE_MAX:0]                         prev_sel,
    input  wwsm_pkg::wwsm_mode_t                        mode,
    output logic                                        hit
);
    import wwsm_pkg::*;

    localparam int CMP_W = (CNT_W > NEEDLE_LEN_W) ? CNT_W : NEEDLE_LEN_W;

    logic [NEEDLE_MAX-1:0] pos_ok;
    logic [NEEDLE_MAX:0]   prev_hit;
    logic                  enough, beyond, prev_word;

    for (genvar k = 0; k < NEEDLE_MAX; k++) begin : g_cmp
        assign pos_ok[k] = !care[k] || (fold_char(window[k], mode.match_case) == align[k]);
    end

    for (genvar k = 0; k <= NEEDLE_MAX; k++) begin : g_prev
        assign prev_hit[k] = prev_sel[k] && !is_sep(window[k]);
    end

    assign enough    = CMP_W'(count) >= CMP_W'(mode.len);
    assign beyond    = CMP_W'(count) >  CMP_W'(mode.len);
    assign prev_word = |prev_hit;

    assign hit = mode.len_ok && enough && (&pos_ok) &&
                 (!mode.whole_word || ((!beyond || !prev_word) && follower_sep));

endmodule

### design/whole_word_substring_match_core.sv
// Top level of the whole-word substring matcher: input register, line state, result register.
// Depends on wwsm_pkg, wwsm_cfg and wwsm_match.
//
//  channel | ports                                  | direction
//  s_      | s_valid s_ready s_line_char s_end_of_line | in, one char item
//  m_      | m_valid m_ready m_found                | out, one item per line
//  cfg_    | cfg_valid cfg_ready cfg_index cfg_data | in, register write
//
// One char item per cycle unless input is held off; an item waits in the input register,
// and the line state and result register update from parallel window compares as it leaves.
// A result is registered as the line's last char leaves the input register, later only while
// the previous result is still held.
// Reset clears all control and config state, not data registers; no clearing pass is needed.
// A stalled result only holds back an end-of-line item; cfg_valid holds off input.
module whole_word_substring_match_core #(
    parameter int NEEDLE_MAX     = wwsm_pkg::NEEDLE_MAX_DEF,
    parameter int MAX_LINE_CHARS = wwsm_pkg::MAX_LINE_CHARS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [wwsm_pkg::CHAR_W-1:0]      s_line_char,
    input  logic                             s_end_of_line,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_found,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [wwsm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wwsm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import wwsm_pkg::*;

    localparam int CNT_W = $clog2(MAX_LINE_CHARS + 1);

    logic [NEEDLE_MAX-1:0][CHAR_W-1:0] align;
    logic [NEEDLE_MAX-1:0]             care;
    logic [NEEDLE_MAX:0]               prev_sel;
    wwsm_mode_t                        mode;

    logic                              in_valid_reg;
    logic [CHAR_W-1:0]                 in_char_reg;
    logic                              in_eol_reg;

    logic [NEEDLE_MAX:0][CHAR_W-1:0]   window_reg, window_next, window_new;
    logic [CNT_W-1:0]                  chars_seen_reg, chars_seen_next, cnt_new;
    logic                              stopped_reg, stopped_next;
    logic                              pending_reg, pending_next;
    logic                              match_reg, match_next;
    logic                              out_valid_reg, out_valid_next;
    logic                              found_reg, found_next;

    logic                              advance, stop_char, follower_sep, at_max;
    logic                              hit_old, hit_new;

    wwsm_cfg #(.NEEDLE_MAX(NEEDLE_MAX)) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .align     (align),
        .care      (care),
        .prev_sel  (prev_sel),
        .mode      (mode)
    );

    assign cfg_ready = 1'b1;

    assign advance = in_valid_reg && (!in_eol_reg || !out_valid_reg || m_ready);
    assign s_ready = (!in_valid_reg || advance) && !cfg_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_line_char;
            in_eol_reg  <= s_end_of_line;
        end
    end

    assign stop_char    = (in_char_reg == '0) || in_char_reg[CHAR_W-1];
    assign follower_sep = stop_char || is_sep(in_char_reg);
    assign window_new   = {window_reg[NEEDLE_MAX-1:0], in_char_reg};
    assign cnt_new      = chars_seen_reg + CNT_W'(1);
    assign at_max       = cnt_new >= CNT_W'(MAX_LINE_CHARS);

    wwsm_match #(.NEEDLE_MAX(NEEDLE_MAX), .CNT_W(CNT_W)) u_match_old (
        .window       (window_reg),
        .count        (chars_seen_reg),
        .follower_sep (follower_sep),
        .align        (align),
        .care         (care),
        .prev_sel     (prev_sel),
        .mode         (mode),
        .hit          (hit_old)
    );

    wwsm_match #(.NEEDLE_MAX(NEEDLE_MAX), .CNT_W(CNT_W)) u_match_new (
        .window       (window_new),
        .count        (cnt_new),
        .follower_sep (1'b1),
        .align        (align),
        .care         (care),
        .prev_sel     (prev_sel),
        .mode         (mode),
        .hit          (hit_new)
    );

    always_comb begin
        window_next     = window_reg;
        chars_seen_next = chars_seen_reg;
        stopped_next    = stopped_reg;
        pending_next    = pending_reg;
        match_next      = match_reg;
        found_next      = found_reg;
        if (advance) begin
            if (!stopped_reg) begin
                match_next = match_reg || (pending_reg && hit_old);
                if (stop_char) begin
                    pending_next = 1'b0;
                    stopped_next = 1'b1;
                end else begin
                    window_next     = window_new;
                    chars_seen_next = cnt_new;
                    if (at_max) begin
                        match_next   = match_next || hit_new;
                        pending_next = 1'b0;
                        stopped_next = 1'b1;
                    end else begin
                        pending_next = 1'b1;
                    end
                end
            end
            if (in_eol_reg) begin
                // a pending check here always refers to the freshly shifted window
                found_next      = match_next || (pending_next && hit_new);
                chars_seen_next = '0;
                stopped_next    = 1'b0;
                pending_next    = 1'b0;
                match_next      = 1'b0;
            end
        end
    end

    always_comb begin
        if (advance && in_eol_reg) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chars_seen_reg <= '0;
            stopped_reg    <= 1'b0;
            pending_reg    <= 1'b0;
            match_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            chars_seen_reg <= chars_seen_next;
            stopped_reg    <= stopped_next;
            pending_reg    <= pending_next;
            match_reg      <= match_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        window_reg <= window_next;
        found_reg  <= found_next;
    end

    assign m_valid = out_valid_reg;
    assign m_found = found_reg;

`ifndef SYNTHESIS
    a_stop_clears_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        stopped_reg |-> !pending_reg)
        else $error("pending check left while scan is stopped");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        chars_seen_reg <= CNT_W'(MAX_LINE_CHARS))
        else $error("char count beyond line limit");

    a_limit_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        (chars_seen_reg == CNT_W'(MAX_LINE_CHARS)) |-> stopped_reg)
        else $error("line limit reached without stopping the scan");

    a_eol_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_eol_reg) |=> (m_valid && chars_seen_reg == '0 && !stopped_reg
                                     && !match_reg))
        else $error("end of line did not post a result and clear line state");

    a_cfg_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> !s_ready)
        else $error("input item taken during a register write");
`endif

endmodule
